@@ hdl/rxr_pkg.sv @@
// shared types and constants for the dma receive ring reader
// no dependencies; used by the top level module and the testbench
`default_nettype none

package rxr_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_WRAP  = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;

  localparam logic [7:0] EMPTY_BYTE = 8'h00;
  localparam logic [8:0] MIN_SIZE   = 9'd2;
  localparam logic [8:0] MAX_RING   = 9'd256;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic [8:0] remaining_count;
  } rxr_in_t;

  typedef struct packed {
    logic       got_byte;
    logic [7:0] data_byte;
    logic       overrun_seen;
    logic [8:0] peak_fill;
    logic [8:0] fill_after;
  } rxr_out_t;

endpackage

`default_nettype wire

@@ hdl/rxr_ring_mem.sv @@
// ring byte store: one write port, one read port, registered read data
// no package dependency
`default_nettype none

module rxr_ring_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/dma_rx_ring_reader_unit.sv @@
// top level of the dma receive ring reader: pop sequencer and counters
// depends on rxr_pkg and rxr_ring_mem
`default_nettype none

// Reader side of a byte ring that a DMA engine fills. Each input beat is one
// of three kinds: a DMA byte write (stored in the ring memory at write_index),
// a DMA wrap event (counts one full pass of the writer), or a pop request
// carrying the DMA remaining-count sample. Writes, wraps and unused kinds are
// accepted back to back. A pop with a usable sample runs a fixed sequence:
// ST_MUL checks the sample and multiplies laps by the ring size, ST_FILL forms
// the write total and unread fill (with overrun clamp and read pointer
// rebase), ST_READ issues the ring memory read, and ST_DATA takes the
// registered read data, so the input stalls from the accepted pop until the
// result beat is loaded into the output register at the end of ST_DATA. The
// multiplier and the single ring memory read port set this sequence.
// Ambiguous samples at a wrap boundary go straight from the check to the
// output step, stall the input meanwhile, and give a result with got_byte low
// and fill_after zero. Either path waits longer while the output register
// holds a beat that downstream stalls. The output register lets the input
// take non-pop beats while a result waits to be taken. ring_size is clamped
// to 2..min(256, RING_DEPTH) and must only be written while the block is
// idle. Ring entries are undefined until the DMA writes them; there is no
// clearing pass after reset.
module dma_rx_ring_reader_unit #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // input beats
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rxr_pkg::rxr_in_t in_item,
  // result beats
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rxr_pkg::rxr_out_t     out_item,
  // ring_size register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [8:0]       cfg_data
);

  localparam int AW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MaxSize = (RING_DEPTH < 256) ? RING_DEPTH : 256;
  localparam logic [8:0] MaxSizeW = 9'(MaxSize);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FILL,
    ST_READ,
    ST_DATA
  } state_t;

  state_t state;

  // configuration: effective ring size kept already clamped
  logic [8:0]  ring_size;
  logic [8:0]  size_next;

  // pointer and counter state
  logic [31:0] read_total;
  logic [23:0] write_laps;
  logic [23:0] last_laps;
  logic [7:0]  read_pos;
  logic        overrun_flag;
  logic [8:0]  peak_level;

  // per-pop working registers
  logic [8:0]  sample;
  logic [8:0]  wr_pos;
  logic [31:0] lap_base;
  logic [8:0]  fill;
  logic        got;

  logic        in_fire;
  logic        out_free;
  logic [8:0]  size_m1;
  logic        ambiguous;
  logic [8:0]  sample_sat;
  logic [32:0] mul_full;
  logic [31:0] wr_total;
  logic [31:0] fill_raw;
  logic        overrun;
  logic [8:0]  pos_mod;
  logic [8:0]  rebase_pos;
  logic [8:0]  start_pos;
  logic [8:0]  pos_inc;

  // ring memory ports
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;
  logic [16:0]   wr_idx_wide;
  logic [16:0]   rd_idx_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // clamp the written size into the legal range
  always_comb begin
    if (cfg_data < rxr_pkg::MIN_SIZE) begin
      size_next = rxr_pkg::MIN_SIZE;
    end else if (cfg_data > MaxSizeW) begin
      size_next = MaxSizeW;
    end else begin
      size_next = cfg_data;
    end
  end

  // sample checks and write position
  assign size_m1    = ring_size - 9'd1;
  assign ambiguous  = (write_laps == last_laps) &&
                      ((sample == 9'd0) || (sample > size_m1));
  assign sample_sat = (sample > ring_size) ? ring_size : sample;
  assign mul_full   = {9'd0, write_laps} * {24'd0, ring_size};

  // totals modulo 2^32; fill above ring size means the writer lapped us
  assign wr_total   = lap_base + {23'd0, wr_pos};
  assign fill_raw   = wr_total - read_total;
  assign overrun    = fill_raw > {23'd0, ring_size};
  assign pos_mod    = (wr_pos == ring_size) ? 9'd0 : wr_pos;
  assign rebase_pos = pos_mod + 9'd1;
  assign start_pos  = overrun ? rebase_pos : {1'b0, read_pos};
  assign pos_inc    = {1'b0, read_pos} + 9'd1;

  // memory addressing
  assign wr_idx_wide = 17'(in_item.write_index);
  assign rd_idx_wide = 17'(read_pos);
  assign mem_wr_en   = in_fire && (in_item.kind == rxr_pkg::KIND_WRITE) &&
                       (32'(in_item.write_index) < 32'(RING_DEPTH));
  assign mem_wr_addr = wr_idx_wide[AW-1:0];
  assign mem_rd_en   = (state == ST_READ) && (fill != 9'd0);
  assign mem_rd_addr = rd_idx_wide[AW-1:0];

  rxr_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (in_item.write_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ring_size    <= MaxSizeW;
      read_total   <= 32'd0;
      write_laps   <= 24'd0;
      last_laps    <= 24'd0;
      read_pos     <= 8'd0;
      overrun_flag <= 1'b0;
      peak_level   <= 9'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ring_size <= size_next;
      end

      // result beat taken downstream, unless st_data loads the next one
      if (out_valid && !out_stall && (state != ST_DATA)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_item.kind)
              rxr_pkg::KIND_WRAP: begin
                write_laps <= write_laps + 24'd1;
              end
              rxr_pkg::KIND_POP: begin
                sample <= in_item.remaining_count;
                state  <= ST_MUL;
              end
              default: begin
                // byte writes go straight to memory, unused kind dropped
              end
            endcase
          end
        end

        ST_MUL: begin
          if (ambiguous) begin
            got   <= 1'b0;
            fill  <= 9'd0;
            state <= ST_DATA;
          end else begin
            if ((sample > 9'd1) && (sample < size_m1)) begin
              last_laps <= write_laps;
            end
            wr_pos   <= ring_size - sample_sat;
            lap_base <= mul_full[31:0];
            state    <= ST_FILL;
          end
        end

        ST_FILL: begin
          if (overrun) begin
            overrun_flag <= 1'b1;
            fill         <= ring_size;
            read_total   <= wr_total - {23'd0, ring_size};
          end else begin
            fill <= fill_raw[8:0];
          end
          // pointer past the ring end (rebase or size change) restarts at 0
          if (start_pos >= ring_size) begin
            read_pos <= 8'd0;
          end else begin
            read_pos <= start_pos[7:0];
          end
          state <= ST_READ;
        end

        ST_READ: begin
          if (fill != 9'd0) begin
            if (fill >= peak_level) begin
              peak_level <= fill;
            end
            got        <= 1'b1;
            read_total <= read_total + 32'd1;
            read_pos   <= (pos_inc >= ring_size) ? 8'd0 : pos_inc[7:0];
            fill       <= fill - 9'd1;
          end else begin
            got <= 1'b0;
          end
          state <= ST_DATA;
        end

        ST_DATA: begin
          // hold until the output register can take the beat
          if (out_free) begin
            out_item.got_byte     <= got;
            out_item.data_byte    <= got ? mem_rd_data : rxr_pkg::EMPTY_BYTE;
            out_item.overrun_seen <= overrun_flag;
            out_item.peak_fill    <= peak_level;
            out_item.fill_after   <= fill;
            out_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ dv/dma_rx_ring_reader_unit_test.sv @@
// testbench for dma_rx_ring_reader_unit: drives ring writes, wrap events and pops
// predicts every pop result in a scoreboard class; needs rxr_pkg and the hdl sources
`timescale 1ns / 1ps

module dma_rx_ring_reader_unit_test;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         STORE_DEPTH  = 256;
  localparam int         DRAIN_CYCLES = 12;      // covers the pop sequence plus output reg
  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         HOLD_CYCLES  = 400;

  // reader registers as the block keeps them
  typedef struct {
    logic [31:0] rd_total;
    logic [23:0] laps;
    logic [23:0] laps_acked;
    logic [7:0]  rd_ptr;
    logic        ovf;
    logic [8:0]  peak;
  } reader_regs_t;

  class ring_scoreboard;
    reader_regs_t       regs;
    logic [7:0]         store [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [8:0]         size_reg;
    rxr_pkg::rxr_out_t  pops_due [$];
    int                 errors;
    int                 n_checked;
    int                 n_bytes;

    function new();
      regs     = '{default: '0};
      size_reg = 9'd256;
      errors   = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_size(logic [8:0] v);
      size_reg = v;
    endfunction

    function logic [8:0] eff();
      if (size_reg < rxr_pkg::MIN_SIZE) return rxr_pkg::MIN_SIZE;
      if (size_reg > rxr_pkg::MAX_RING) return rxr_pkg::MAX_RING;
      return size_reg;
    endfunction

    function int pending();
      return pops_due.size();
    endfunction

    // pop arithmetic on a set of registers; slot is the ring entry read, or -1
    function void pop_math(inout reader_regs_t s, input logic [8:0] remaining,
                           output rxr_pkg::rxr_out_t r, output int slot);
      logic [8:0]  m, h, pos, rp;
      logic [31:0] wtotal, fill;
      m           = eff();
      slot        = -1;
      r           = '0;
      r.data_byte = rxr_pkg::EMPTY_BYTE;
      h           = remaining;
      // sample at a wrap boundary with no new lap: cannot tell full from empty
      if (s.laps == s.laps_acked && (h < 9'd1 || h > m - 9'd1)) begin
        r.overrun_seen = s.ovf;
        r.peak_fill    = s.peak;
        return;
      end
      if (h > 9'd1 && h < m - 9'd1) s.laps_acked = s.laps;
      if (h > m) h = m;
      pos    = m - h;
      wtotal = 32'(s.laps) * 32'(m) + 32'(pos);
      fill   = wtotal - s.rd_total;
      rp     = {1'b0, s.rd_ptr};
      if (fill > 32'(m)) begin
        // writer lapped us: keep the newest ring worth of data
        s.ovf      = 1'b1;
        fill       = 32'(m);
        s.rd_total = wtotal - 32'(m);
        rp         = (pos % m) + 9'd1;
        if (rp >= m) rp = '0;
      end
      if (rp >= m) rp = '0;
      if (fill != 32'd0) begin
        if (fill[8:0] >= s.peak) s.peak = fill[8:0];
        slot       = int'(rp);
        r.got_byte = 1'b1;
        s.rd_total = s.rd_total + 32'd1;
        rp         = rp + 9'd1;
        if (rp >= m) rp = '0;
        fill       = fill - 32'd1;
      end
      s.rd_ptr       = rp[7:0];
      r.overrun_seen = s.ovf;
      r.peak_fill    = s.peak;
      r.fill_after   = fill[8:0];
    endfunction

    // ring entry a pop would read right now, without changing anything
    function int read_slot(rxr_pkg::rxr_in_t it);
      reader_regs_t      scratch;
      rxr_pkg::rxr_out_t r;
      int                slot;
      scratch = regs;
      pop_math(scratch, it.remaining_count, r, slot);
      return slot;
    endfunction

    function void note_input(rxr_pkg::rxr_in_t it);
      rxr_pkg::rxr_out_t r;
      int                slot;
      case (it.kind)
        rxr_pkg::KIND_WRITE: begin
          store[it.write_index]   = it.write_data;
          written[it.write_index] = 1'b1;
        end
        rxr_pkg::KIND_WRAP: regs.laps = regs.laps + 24'd1;
        rxr_pkg::KIND_POP: begin
          pop_math(regs, it.remaining_count, r, slot);
          if (slot >= 0) r.data_byte = store[slot];
          pops_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, logic [8:0] e, logic [8:0] a);
      if (e !== a) begin
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(rxr_pkg::rxr_out_t act);
      rxr_pkg::rxr_out_t e;
      bit                ok;
      if (pops_due.size() == 0) begin
        $display("%0t: result beat with no pop waiting: expected none, actual %0h",
                 $time, act);
        errors++;
        return;
      end
      e  = pops_due.pop_front();
      ok = field_ok("got_byte", 9'(e.got_byte), 9'(act.got_byte));
      ok = field_ok("data_byte", 9'(e.data_byte), 9'(act.data_byte)) && ok;
      ok = field_ok("overrun_seen", 9'(e.overrun_seen), 9'(act.overrun_seen)) && ok;
      ok = field_ok("peak_fill", e.peak_fill, act.peak_fill) && ok;
      ok = field_ok("fill_after", e.fill_after, act.fill_after) && ok;
      if (!ok) errors++;
      n_checked++;
      if (act.got_byte) n_bytes++;
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  rxr_pkg::rxr_in_t  in_item;
  logic              out_valid;
  logic              out_stall;
  rxr_pkg::rxr_out_t out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [8:0]        cfg_data;

  ring_scoreboard sb = new;

  int  send_idle_pct;      // only the stimulus process reads this
  int  stall_pct;          // read by the receiver, written by nonblocking assignment
  bit  press_go;
  logic holding;
  int  dma_pos;            // next ring index the modeled dma writes
  bit  wrap_due;           // dma wrote the last slot, wrap event comes next
  int  cycles;
  logic [8:0] phase_sizes [8];

  dma_rx_ring_reader_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

  // result side: check each accepted beat, then pick the stall for the next edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
    out_stall <= holding || ($urandom_range(99) < stall_pct);
  end

  // long receiver hold-off so the output register fills and the input backs up
  initial begin
    holding = 1'b0;
    wait (press_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  function automatic rxr_pkg::rxr_in_t beat_of(logic [1:0] k, logic [7:0] idx,
                                               logic [7:0] d, logic [8:0] rem);
    rxr_pkg::rxr_in_t b;
    b.kind            = k;
    b.write_index     = idx;
    b.write_data      = d;
    b.remaining_count = rem;
    return b;
  endfunction

  // one input beat: random idle cycles first, then hold until accepted
  task automatic send_beat(input rxr_pkg::rxr_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  // a pop that would read a never-written ring entry gets that entry written first
  task automatic issue(input rxr_pkg::rxr_in_t it);
    int slot;
    if (it.kind == rxr_pkg::KIND_POP) begin
      slot = sb.read_slot(it);
      if (slot >= 0 && !sb.written[slot])
        send_beat(beat_of(rxr_pkg::KIND_WRITE, slot[7:0], 8'($urandom), 9'($urandom)));
    end
    send_beat(it);
  endtask

  // ring_size write, only once the block has drained
  task automatic write_size(input logic [8:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_size(v);
    dma_pos  = 0;
    wrap_due = 1'b0;
  endtask

  // mostly an orderly dma filling the ring in sequence with pops sampling its
  // true remaining count; a slice of stray writes, odd samples, spare wraps and
  // unused kinds on top
  task automatic run_random(input int n, input int write_pct);
    logic [8:0] m;
    int         r;
    repeat (n) begin
      m = sb.eff();
      r = $urandom_range(99);
      if (r < write_pct) begin
        if (wrap_due) begin
          issue(beat_of(rxr_pkg::KIND_WRAP, 8'($urandom), 8'($urandom), 9'($urandom)));
          dma_pos  = 0;
          wrap_due = 1'b0;
        end else begin
          issue(beat_of(rxr_pkg::KIND_WRITE, 8'(dma_pos), 8'($urandom), 9'($urandom)));
          dma_pos++;
          if (dma_pos >= int'(m)) wrap_due = 1'b1;
        end
      end else if (r < 92) begin
        // remaining count reads 0 between the last write of a pass and its wrap
        issue(beat_of(rxr_pkg::KIND_POP, 8'($urandom), 8'($urandom),
                      wrap_due ? 9'd0 : 9'(int'(m) - dma_pos)));
      end else begin
        case ($urandom_range(3))
          0: issue(beat_of(rxr_pkg::KIND_WRITE, 8'($urandom), 8'($urandom), 9'($urandom)));
          1: issue(beat_of(rxr_pkg::KIND_POP, 8'($urandom), 8'($urandom), 9'($urandom)));
          2: issue(beat_of(KIND_UNUSED, 8'($urandom), 8'($urandom), 9'($urandom)));
          default: issue(beat_of(rxr_pkg::KIND_WRAP, 8'($urandom), 8'($urandom),
                                 9'($urandom)));
        endcase
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    press_go      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    dma_pos       = 0;
    wrap_due      = 1'b0;
    phase_sizes   = '{9'd256, 9'd17, 9'd2, 9'd511, 9'd3, 9'd100, 9'd0, 9'd255};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset ring size of 256
    issue(beat_of(rxr_pkg::KIND_WRITE, 8'd0, 8'hFF, 9'd0));
    issue(beat_of(rxr_pkg::KIND_WRITE, 8'd255, 8'h00, 9'h1FF));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd256));   // full-pass sample, no lap: skipped
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd0));     // zero sample, no lap: skipped
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'h1FF));   // oversize sample, no lap: skipped
    issue(beat_of(rxr_pkg::KIND_POP, 8'hFF, 8'hFF, 9'd255)); // one byte written, one popped
    issue(beat_of(KIND_UNUSED, 8'hFF, 8'hFF, 9'h1FF));       // ignored
    issue(beat_of(rxr_pkg::KIND_WRAP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'h1FF));   // saturates to write position 0
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd128));   // mid-ring sample marks the lap
    issue(beat_of(rxr_pkg::KIND_WRAP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_WRAP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_WRAP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd2));     // writer lapped reader: overrun
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd1));
    // smallest ring, read pointer beyond the new size restarts
    write_size(9'd2);
    issue(beat_of(rxr_pkg::KIND_WRITE, 8'd1, 8'h55, 9'd0));
    issue(beat_of(rxr_pkg::KIND_WRITE, 8'd0, 8'hAA, 9'd0));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd1));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd2));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_WRAP, 8'd0, 8'd0, 9'd0));
    issue(beat_of(rxr_pkg::KIND_POP, 8'd0, 8'd0, 9'd2));

    // random phases: ring size and idle mix change between them
    for (int ph = 0; ph < 8; ph++) begin
      write_size(phase_sizes[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 83; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 83; end
        default: begin send_idle_pct = 8; stall_pct <= 8; end
      endcase
      if (ph == 4) press_go <= 1'b1;
      run_random(53, (ph % 2 == 1) ? 80 : 55);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d pop results, %0d of them carried a byte", sb.n_checked, sb.n_bytes);
    $display("ring sizes 2 to 256 incl. clamped writes, four idle mixes, one long hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ dma_rx_ring_reader_unit.f @@
hdl/rxr_pkg.sv
hdl/rxr_ring_mem.sv
hdl/dma_rx_ring_reader_unit.sv
dv/dma_rx_ring_reader_unit_test.sv
